FILE: src/ped_pkg.sv
// types, codes and the hex digit helper for the percent-escape decoder
// no dependencies; imported by ped_step and percent_escape_decoder
package ped_pkg;

  localparam logic [7:0] PCT_CHAR = 8'h25;
  localparam logic [7:0] CHAR_0   = 8'h30;
  localparam logic [7:0] CHAR_9   = 8'h39;
  localparam logic [7:0] CHAR_LA  = 8'h61;
  localparam logic [7:0] CHAR_LF  = 8'h66;
  localparam logic [7:0] CHAR_UA  = 8'h41;
  localparam logic [7:0] CHAR_UF  = 8'h46;
  localparam int unsigned MAX_RES = 3;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // results of one request and the state it leaves
  typedef struct packed {
    out_item_t [MAX_RES-1:0] items;
    logic [1:0]              cnt;
    phase_t                  phase;
    logic [7:0]              held;
  } step_res_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (c >= CHAR_0 && c <= CHAR_9) begin
        d = c - CHAR_0;
        hex_value = {1'b1, d[3:0]};
      end else if (c >= CHAR_LA && c <= CHAR_LF) begin
        d = c - CHAR_LA + 8'd10;
        hex_value = {1'b1, d[3:0]};
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
        d = c - CHAR_UA + 8'd10;
        hex_value = {1'b1, d[3:0]};
      end else begin
        hex_value = 5'b0_0000;
      end
    end
  endfunction

endpackage

FILE: src/percent_escape_decoder.sv
// percent-escape decoder top level: escape state, result buffer, handshakes
// depends on ped_pkg and ped_step
//
// Usage: one text byte per input request on in_data (in_byte, in_last),
// decoded bytes leave on out_data (out_byte, out_last), both channels with
// valid/ready. A '%' and two hex digits become one byte; "%00" and broken
// escapes pass as written. A pending '%' and first digit are kept across
// requests and flushed at in_last, where out_last marks the final result.
// Latency: a request's first result is valid the cycle after acceptance.
// Throughput: one request per cycle while each gives at most one result
// and out_ready stays high; a request giving more holds the input until
// its last result leaves the three-entry buffer, one entry per ready cycle.
// in_ready is high when the buffer is empty or its last entry leaves in
// the same cycle, so a stalled receiver stops input after one result.
// Reset (rst_n low, synchronous) empties the buffer and drops any pending
// escape.
module percent_escape_decoder import ped_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  phase_t                  phase_r;
  logic [7:0]              held_r;
  out_item_t [MAX_RES-1:0] buf_r;
  logic [1:0]              cnt_r;
  step_res_t               step;
  logic                    in_fire;
  logic                    out_fire;

  ped_step u_step (
    .item     (in_data),
    .phase_in (phase_r),
    .held_in  (held_r),
    .res      (step)
  );

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = buf_r[0];
  assign out_fire  = out_valid && out_ready;
  assign in_ready  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'h00;
      cnt_r   <= 2'd0;
    end else begin
      if (in_fire) begin
        phase_r <= step.phase;
        held_r  <= step.held;
        cnt_r   <= step.cnt;
      end else if (out_fire) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // payload buffer, entry 0 is presented
  always_ff @(posedge clk) begin
    if (in_fire) begin
      buf_r <= step.items;
    end else if (out_fire) begin
      buf_r <= {buf_r[MAX_RES-1], buf_r[MAX_RES-1:1]};
    end
  end

endmodule

FILE: src/ped_step.sv
// combinational decode of one request against the held escape state
// depends on ped_pkg
module ped_step import ped_pkg::*; (
  input  in_item_t   item,
  input  phase_t     phase_in,
  input  logic [7:0] held_in,
  output step_res_t  res
);

  always_comb begin
    logic [1:0] n;
    logic [4:0] hv;
    logic [4:0] h1;
    logic [7:0] val;
    logic [7:0] b;
    res = '0;
    n = 2'd0;
    b = item.in_byte;
    hv = hex_value(b);
    h1 = hex_value(held_in);
    val = {h1[4] ? h1[3:0] : 4'h0, hv[3:0]};
    res.phase = phase_in;
    res.held = held_in;
    case (phase_in)
      PH_PCT: begin
        if (hv[4]) begin
          res.held = b;
          res.phase = PH_DIGIT;
        end else begin
          res.items[n].out_byte = PCT_CHAR;
          n = n + 2'd1;
          if (b == PCT_CHAR) begin
            res.phase = PH_PCT;
          end else begin
            res.items[n].out_byte = b;
            n = n + 2'd1;
            res.phase = PH_IDLE;
          end
        end
      end
      PH_DIGIT: begin
        if (hv[4] && val != 8'h00) begin
          res.items[n].out_byte = val;
          n = n + 2'd1;
          res.phase = PH_IDLE;
        end else begin
          // not a valid escape, or the null escape: pass it as written
          res.items[n].out_byte = PCT_CHAR;
          n = n + 2'd1;
          res.items[n].out_byte = held_in;
          n = n + 2'd1;
          if (b == PCT_CHAR) begin
            res.phase = PH_PCT;
          end else begin
            res.items[n].out_byte = b;
            n = n + 2'd1;
            res.phase = PH_IDLE;
          end
        end
      end
      default: begin
        if (b == PCT_CHAR) begin
          res.phase = PH_PCT;
        end else begin
          res.items[n].out_byte = b;
          n = n + 2'd1;
          res.phase = PH_IDLE;
        end
      end
    endcase
    if (item.in_last) begin
      // flush whatever escape is still pending
      if (res.phase == PH_PCT) begin
        res.items[n].out_byte = PCT_CHAR;
        n = n + 2'd1;
      end else if (res.phase == PH_DIGIT) begin
        res.items[n].out_byte = PCT_CHAR;
        n = n + 2'd1;
        res.items[n].out_byte = res.held;
        n = n + 2'd1;
      end
      res.phase = PH_IDLE;
      if (n != 2'd0) begin
        res.items[n - 2'd1].out_last = 1'b1;
      end
    end
    res.cnt = n;
  end

endmodule

FILE: verif/tb.sv
// self-checking testbench for percent_escape_decoder: directed table, then random strings
// depends on ped_pkg and the decoder RTL; holds its own escape-decoding predictor
module tb import ped_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]      ch;
    logic            last;
    logic            typed;
    logic [1:0]      cnt;
    logic [0:2][7:0] exp_bytes;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  phase_t    esc_phase;
  logic [7:0] esc_held;
  out_item_t step_bytes[$];
  out_item_t decoded_q[$];
  int        mismatch_count = 0;
  int        req_count = 0;
  bit        calm = 1'b0;

  // typed rows: expected bytes as read off the escape rules, last on final byte
  dir_row_t dir_table [0:24] = '{
    {8'h41,    1'b0, 1'b1, 2'd1, 24'h41_00_00},
    {8'hFF,    1'b0, 1'b1, 2'd1, 24'hFF_00_00},
    {8'h01,    1'b1, 1'b1, 2'd1, 24'h01_00_00},
    {PCT_CHAR, 1'b0, 1'b1, 2'd0, 24'h00_00_00},
    {8'h34,    1'b0, 1'b1, 2'd0, 24'h00_00_00},
    {8'h31,    1'b0, 1'b1, 2'd1, 24'h41_00_00},
    {PCT_CHAR, 1'b0, 1'b1, 2'd0, 24'h00_00_00},
    {8'h66,    1'b0, 1'b1, 2'd0, 24'h00_00_00},
    {8'h46,    1'b1, 1'b1, 2'd1, 24'hFF_00_00},
    // zero escape passes as written
    {PCT_CHAR, 1'b0, 1'b1, 2'd0, 24'h00_00_00},
    {8'h30,    1'b0, 1'b1, 2'd0, 24'h00_00_00},
    {8'h30,    1'b0, 1'b1, 2'd3, 24'h25_30_30},
    // double percent, second one starts a fresh escape
    {PCT_CHAR, 1'b0, 1'b0, 2'd0, 24'h00_00_00},
    {PCT_CHAR, 1'b0, 1'b0, 2'd0, 24'h00_00_00},
    {8'h34,    1'b0, 1'b0, 2'd0, 24'h00_00_00},
    {8'h31,    1'b1, 1'b0, 2'd0, 24'h00_00_00},
    {PCT_CHAR, 1'b0, 1'b1, 2'd0, 24'h00_00_00},
    {8'h67,    1'b0, 1'b1, 2'd2, 24'h25_67_00},
    {PCT_CHAR, 1'b0, 1'b0, 2'd0, 24'h00_00_00},
    {8'h61,    1'b0, 1'b0, 2'd0, 24'h00_00_00},
    {8'h7A,    1'b1, 1'b1, 2'd3, 24'h25_61_7A},
    // flushes at string end
    {PCT_CHAR, 1'b1, 1'b1, 2'd1, 24'h25_00_00},
    {PCT_CHAR, 1'b0, 1'b0, 2'd0, 24'h00_00_00},
    {8'h42,    1'b1, 1'b1, 2'd2, 24'h25_42_00},
    {8'h80,    1'b0, 1'b1, 2'd1, 24'h80_00_00}
  };

  percent_escape_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000;
    $display("percent_escape_decoder: mismatch");
    $finish;
  end

  function automatic int nibble_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int k;
    k = $urandom_range(21);
    if (k < 10) return 8'h30 + k[7:0];
    if (k < 16) return 8'h61 + k[7:0] - 8'd10;
    return 8'h41 + k[7:0] - 8'd16;
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(255, 1)); while (nibble_of(b) >= 0);
    return b;
  endfunction

  // byte with nothing held
  task automatic take_plain(logic [7:0] b);
    if (b == PCT_CHAR) begin
      esc_phase = PH_PCT;
    end else begin
      step_bytes.push_back(out_item_t'({b, 1'b0}));
      esc_phase = PH_IDLE;
    end
  endtask

  // fills step_bytes with the bytes one request produces
  task automatic decode_request(in_item_t req);
    int nib;
    int h1;
    step_bytes.delete();
    nib = nibble_of(req.in_byte);
    case (esc_phase)
      PH_PCT: begin
        if (nib >= 0) begin
          esc_held = req.in_byte;
          esc_phase = PH_DIGIT;
        end else begin
          step_bytes.push_back(out_item_t'({PCT_CHAR, 1'b0}));
          take_plain(req.in_byte);
        end
      end
      PH_DIGIT: begin
        h1 = nibble_of(esc_held);
        if (h1 < 0) h1 = 0;
        if (nib >= 0 && (h1 * 16 + nib) != 0) begin
          step_bytes.push_back(out_item_t'({8'(h1 * 16 + nib), 1'b0}));
          esc_phase = PH_IDLE;
        end else begin
          step_bytes.push_back(out_item_t'({PCT_CHAR, 1'b0}));
          step_bytes.push_back(out_item_t'({esc_held, 1'b0}));
          take_plain(req.in_byte);
        end
      end
      default: take_plain(req.in_byte);
    endcase
    if (req.in_last) begin
      if (esc_phase == PH_PCT) begin
        step_bytes.push_back(out_item_t'({PCT_CHAR, 1'b0}));
      end else if (esc_phase == PH_DIGIT) begin
        step_bytes.push_back(out_item_t'({PCT_CHAR, 1'b0}));
        step_bytes.push_back(out_item_t'({esc_held, 1'b0}));
      end
      esc_phase = PH_IDLE;
      if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].out_last = 1'b1;
    end
  endtask

  task automatic send_request(in_item_t req, logic typed, logic [1:0] cnt,
                              logic [0:2][7:0] exp_bytes);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_request(req);
    if (typed) begin
      for (int k = 0; k < cnt; k++)
        decoded_q.push_back(out_item_t'({exp_bytes[k], req.in_last && (k == cnt - 1)}));
    end else begin
      foreach (step_bytes[k]) decoded_q.push_back(step_bytes[k]);
    end
    req_count++;
  endtask

  // receiver stalls at random
  initial begin
    forever begin
      @(negedge clk);
      out_ready <= rst_n && (calm || $urandom_range(99) >= 9);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected output: byte %h last %b", out_data.out_byte, out_data.out_last);
      end else begin
        out_item_t want;
        want = decoded_q.pop_front();
        if (out_data.out_byte !== want.out_byte || out_data.out_last !== want.out_last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("output %0d: expected byte %h last %b, got byte %h last %b",
                     mismatch_count, want.out_byte, want.out_last,
                     out_data.out_byte, out_data.out_last);
        end
      end
    end
  end

  initial begin
    logic [7:0] str_q[$];
    in_item_t   req;
    int         tokens;
    logic [7:0] h;
    esc_phase = PH_IDLE;
    esc_held  = 8'h00;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      req.in_byte = dir_table[i].ch;
      req.in_last = dir_table[i].last;
      send_request(req, dir_table[i].typed, dir_table[i].cnt, dir_table[i].exp_bytes);
    end

    // hold off until the decoder has drained
    @(negedge clk);
    in_valid <= 1'b0;
    wait (decoded_q.size() == 0);

    while (req_count < 170) begin
      calm = (req_count >= 80 && req_count < 120);
      if ($urandom_range(99) < 12) begin
        // noise request
        req.in_byte = 8'($urandom_range(255, 1));
        req.in_last = 1'($urandom_range(1));
        send_request(req, 1'b0, 2'd0, '0);
      end else begin
        str_q.delete();
        tokens = $urandom_range(4, 1);
        repeat (tokens) begin
          case ($urandom_range(13))
            0, 1, 2, 3: str_q.push_back(8'($urandom_range(255, 1)));
            9: begin
              str_q.push_back(PCT_CHAR);
              str_q.push_back(8'h30);
              str_q.push_back(8'h30);
            end
            10: begin
              str_q.push_back(PCT_CHAR);
              str_q.push_back(rand_non_hex());
            end
            11: begin
              h = rand_hex_char();
              str_q.push_back(PCT_CHAR);
              str_q.push_back(h);
              str_q.push_back(rand_non_hex());
            end
            12: str_q.push_back(PCT_CHAR);
            13: begin
              h = rand_hex_char();
              str_q.push_back(PCT_CHAR);
              str_q.push_back(h);
            end
            default: begin
              h = rand_hex_char();
              str_q.push_back(PCT_CHAR);
              str_q.push_back(h);
              str_q.push_back(rand_hex_char());
            end
          endcase
        end
        foreach (str_q[k]) begin
          req.in_byte = str_q[k];
          req.in_last = (k == str_q.size() - 1);
          send_request(req, 1'b0, 2'd0, '0);
        end
        if ($urandom_range(7) == 0) begin
          @(negedge clk);
          in_valid <= 1'b0;
          wait (decoded_q.size() == 0);
        end
      end
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    wait (decoded_q.size() == 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && decoded_q.size() == 0) begin
      $display("percent_escape_decoder: match");
    end else begin
      $display("percent_escape_decoder: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ped_pkg.sv
src/ped_step.sv
src/percent_escape_decoder.sv
verif/tb.sv
